[design/lz77_window_compressor_unit_assert.svh]
// assertion macros for the lz77 window compressor checker
`ifndef LZ77_WINDOW_COMPRESSOR_UNIT_ASSERT_SVH
`define LZ77_WINDOW_COMPRESSOR_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define LZ77WC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lz77wc: check failed");

// next-cycle implication, sampled on clk, quiet during reset
`define LZ77WC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lz77wc: check failed");

`endif

[design/lz77wc_pkg.sv]
// shared types and constants of the lz77 window compressor
`default_nettype none
package lz77wc_pkg;

	localparam int BYTE_W   = 8;
	localparam int WSIZE_W  = 11;
	localparam int LSIZE_W  = 5;
	localparam int OFFSET_W = 11;
	localparam int MLEN_W   = 5;
	localparam int CIDX_W   = 2;
	localparam int MIN_MATCH = 3;

	localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RST    = 11'd1024;
	localparam logic [LSIZE_W-1:0] LOOKAHEAD_SIZE_RST = 5'd16;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_WINDOW_SIZE    = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_LOOKAHEAD_SIZE = 2'd1;

	// token kinds
	localparam logic TAG_MATCH   = 1'b0;
	localparam logic TAG_LITERAL = 1'b1;

	// queued input word
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              last;
	} inq_word_t;

	// result token
	typedef struct packed {
		logic                tag;
		logic [OFFSET_W-1:0] offset;
		logic [MLEN_W-1:0]   match_length;
		logic [BYTE_W-1:0]   literal_byte;
		logic                final_res;
	} token_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_CHECK,
		BK_SEARCH,
		BK_EMIT,
		BK_PUSH
	} bk_state_t;

endpackage
`default_nettype wire

[design/lz77wc_if.sv]
// channel interfaces: input bytes and output tokens
`default_nettype none
interface lz77wc_in_if;
	logic                           valid;
	logic                           ready;
	logic [lz77wc_pkg::BYTE_W-1:0]  data_byte;
	logic                           last;
	modport source(output valid, output data_byte, output last, input ready);
	modport sink(input valid, input data_byte, input last, output ready);
endinterface

interface lz77wc_out_if;
	logic                            valid;
	logic                            ready;
	logic                            tag;
	logic [lz77wc_pkg::OFFSET_W-1:0] offset;
	logic [lz77wc_pkg::MLEN_W-1:0]   match_length;
	logic [lz77wc_pkg::BYTE_W-1:0]   literal_byte;
	logic                            final_res;
	modport source(output valid, output tag, output offset, output match_length,
		output literal_byte, output final_res, input ready);
	modport sink(input valid, input tag, input offset, input match_length,
		input literal_byte, input final_res, output ready);
endinterface
`default_nettype wire

[design/lz77wc_front.sv]
// front end: takes input words into a two-entry queue
`default_nettype none
module lz77wc_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	lz77wc_in_if.sink                  data,
	output logic                       q_valid,
	input  wire logic                  q_ready,
	output lz77wc_pkg::inq_word_t      q_word
);
	lz77wc_pkg::inq_word_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	// handshake decode
	assign data.ready = (cnt_q != 2'd2);
	assign push       = data.valid && data.ready;
	assign q_valid    = (cnt_q != 2'd0);
	assign pop        = q_valid && q_ready;
	assign q_word     = mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{data_byte: data.data_byte, last: data.last};
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule
`default_nettype wire

[design/lz77wc_back.sv]
// back end: lookahead, history ring, match search and token output
`default_nettype none
module lz77wc_back #(
	parameter int WINDOW    = 1024,
	parameter int LOOKAHEAD = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [lz77wc_pkg::WSIZE_W-1:0]      window_size,
	input  wire logic [lz77wc_pkg::LSIZE_W-1:0]      lookahead_size,
	input  wire logic                                q_valid,
	output logic                                     q_ready,
	input  wire lz77wc_pkg::inq_word_t               q_word,
	output logic                                     tok_valid,
	input  wire logic                                tok_ready,
	output lz77wc_pkg::token_t                       tok
);
	localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int HW = $clog2(WINDOW + 1);
	localparam int LW = $clog2(LOOKAHEAD + 1);
	localparam int IW = $clog2(LOOKAHEAD);
	localparam int KW = $clog2(WINDOW + LOOKAHEAD + 1);
	localparam int SW = AW + 2;

	lz77wc_pkg::bk_state_t state_q, state_d;

	logic [7:0]    hist_mem [WINDOW];
	logic [7:0]    la_q [LOOKAHEAD];
	logic [7:0]    sr_q [LOOKAHEAD];
	logic [LW-1:0] la_cnt_q;
	logic [HW-1:0] hcnt_q;
	logic [AW-1:0] head_q;
	logic          last_q;

	logic [HW-1:0] h_q;
	logic [LW-1:0] bound_q;
	logic [KW-1:0] k_q;
	logic [KW-1:0] feed_end_q;
	logic [AW-1:0] rd_addr_q;
	logic [LW-1:0] best_q;
	logic [HW-1:0] besti_q;
	logic [LW-1:0] push_q;

	logic          v_s1;
	logic          hist_s1;
	logic [7:0]    la_byte_s1;
	logic [7:0]    mem_rd_s1;
	logic [KW-1:0] k_s1;
	logic          v_s2;
	logic [HW-1:0] cand_s2;

	logic          tv_q;
	lz77wc_pkg::token_t tok_q;

	logic [HW-1:0] eff_w;
	logic [LW-1:0] eff_l;
	logic [HW-1:0] h_c;
	logic [LW-1:0] bound_c;
	logic [SW-1:0] start_sum;
	logic [AW-1:0] start_addr;
	logic [KW-1:0] la_off;
	logic [7:0]    byte_s1;
	logic [LW-1:0] len_c;
	logic          run;
	logic [LW-1:0] used_c;
	logic [HW-1:0] dist_c;

	logic pop;
	logic issue;
	logic search_done;
	logic load_tok;
	logic push_en;
	logic check_end;

	// clamp the configuration
	always_comb begin
		if (window_size == '0)           eff_w = HW'(1);
		else if (int'(window_size) > WINDOW) eff_w = HW'(WINDOW);
		else                             eff_w = HW'(window_size);
		if (lookahead_size == '0)              eff_l = LW'(1);
		else if (int'(lookahead_size) > LOOKAHEAD) eff_l = LW'(LOOKAHEAD);
		else                                   eff_l = LW'(lookahead_size);
	end

	// search setup values
	always_comb begin
		h_c       = (hcnt_q < eff_w) ? hcnt_q : eff_w;
		bound_c   = (eff_l < la_cnt_q) ? eff_l : la_cnt_q;
		start_sum = SW'(head_q) + SW'(WINDOW) - SW'(h_c);
		if (start_sum >= SW'(WINDOW)) start_addr = AW'(start_sum - SW'(WINDOW));
		else                          start_addr = AW'(start_sum);
		la_off    = k_q - KW'(h_q);
		byte_s1   = hist_s1 ? mem_rd_s1 : la_byte_s1;
	end

	// match length of the candidate held in the shift window
	always_comb begin
		len_c = '0;
		run   = 1'b1;
		for (int j = 0; j < LOOKAHEAD; j++) begin
			if (run && (LW'(j) < bound_q) && (sr_q[j] == la_q[j])) len_c = len_c + LW'(1);
			else run = 1'b0;
		end
	end

	// token decision
	always_comb begin
		used_c = (best_q >= LW'(lz77wc_pkg::MIN_MATCH)) ? best_q : LW'(1);
		dist_c = h_q - besti_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lz77wc_pkg::BK_IDLE: begin
				if (q_valid) state_d = lz77wc_pkg::BK_CHECK;
			end
			lz77wc_pkg::BK_CHECK: begin
				if (last_q) begin
					state_d = (la_cnt_q != '0) ? lz77wc_pkg::BK_SEARCH : lz77wc_pkg::BK_IDLE;
				end else if ((la_cnt_q != '0) && (la_cnt_q >= eff_l)) begin
					state_d = lz77wc_pkg::BK_SEARCH;
				end else begin
					state_d = lz77wc_pkg::BK_IDLE;
				end
			end
			lz77wc_pkg::BK_SEARCH: begin
				if (search_done) state_d = lz77wc_pkg::BK_EMIT;
			end
			lz77wc_pkg::BK_EMIT: begin
				if (!tv_q || tok_ready) state_d = lz77wc_pkg::BK_PUSH;
			end
			lz77wc_pkg::BK_PUSH: begin
				if (push_q == LW'(1)) state_d = lz77wc_pkg::BK_CHECK;
			end
			default: state_d = lz77wc_pkg::BK_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		q_ready     = (state_q == lz77wc_pkg::BK_IDLE);
		pop         = q_ready && q_valid;
		issue       = (state_q == lz77wc_pkg::BK_SEARCH) && (k_q < feed_end_q);
		search_done = (state_q == lz77wc_pkg::BK_SEARCH) && !(k_q < feed_end_q)
			&& !v_s1 && !v_s2;
		load_tok    = (state_q == lz77wc_pkg::BK_EMIT) && (!tv_q || tok_ready);
		push_en     = (state_q == lz77wc_pkg::BK_PUSH);
		check_end   = (state_q == lz77wc_pkg::BK_CHECK) && last_q && (la_cnt_q == '0);
	end

	assign tok_valid = tv_q;
	assign tok       = tok_q;

	// history ring: one read and one write port
	always_ff @(posedge clk) begin
		if (issue)   mem_rd_s1 <= hist_mem[rd_addr_q];
		if (push_en) hist_mem[head_q] <= la_q[0];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lz77wc_pkg::BK_IDLE;
			la_cnt_q <= '0;
			hcnt_q   <= '0;
			head_q   <= '0;
			last_q   <= 1'b0;
			k_q      <= '0;
			push_q   <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			tv_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			v_s2    <= v_s1 && (k_s1 >= KW'(LOOKAHEAD - 1))
				&& ((k_s1 - KW'(LOOKAHEAD - 1)) < KW'(h_q));
			if (pop) begin
				if (la_cnt_q < LW'(LOOKAHEAD)) la_cnt_q <= la_cnt_q + LW'(1);
				last_q <= q_word.last;
			end
			if (check_end) begin
				hcnt_q <= '0;
				head_q <= '0;
				last_q <= 1'b0;
			end
			if (state_q == lz77wc_pkg::BK_CHECK) k_q <= '0;
			else if (issue)                      k_q <= k_q + KW'(1);
			if (load_tok)      push_q <= used_c;
			else if (push_en)  push_q <= push_q - LW'(1);
			if (push_en) begin
				la_cnt_q <= la_cnt_q - LW'(1);
				head_q   <= (head_q == AW'(WINDOW - 1)) ? '0 : head_q + AW'(1);
				if (hcnt_q < HW'(WINDOW)) hcnt_q <= hcnt_q + HW'(1);
			end
			if (load_tok)       tv_q <= 1'b1;
			else if (tok_ready) tv_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		// lookahead: append on pop, slide on push
		if (pop && (la_cnt_q < LW'(LOOKAHEAD))) la_q[la_cnt_q[IW-1:0]] <= q_word.data_byte;
		if (push_en) begin
			for (int j = 0; j < LOOKAHEAD - 1; j++) la_q[j] <= la_q[j + 1];
		end
		// search setup
		if (state_q == lz77wc_pkg::BK_CHECK) begin
			h_q        <= h_c;
			bound_q    <= bound_c;
			feed_end_q <= KW'(h_c) + KW'(LOOKAHEAD - 1);
			rd_addr_q  <= start_addr;
			best_q     <= '0;
			besti_q    <= '0;
		end
		// feed stage
		if (issue) begin
			rd_addr_q  <= (rd_addr_q == AW'(WINDOW - 1)) ? '0 : rd_addr_q + AW'(1);
			hist_s1    <= (k_q < KW'(h_q));
			la_byte_s1 <= la_q[la_off[IW-1:0]];
			k_s1       <= k_q;
		end
		// shift window, newest byte at the top
		if (v_s1) begin
			for (int j = 0; j < LOOKAHEAD - 1; j++) sr_q[j] <= sr_q[j + 1];
			sr_q[LOOKAHEAD-1] <= byte_s1;
			cand_s2 <= HW'(k_s1 - KW'(LOOKAHEAD - 1));
		end
		// keep the longest, oldest wins a tie
		if (v_s2 && (len_c > best_q)) begin
			best_q  <= len_c;
			besti_q <= cand_s2;
		end
		// token register
		if (load_tok) begin
			if (best_q >= LW'(lz77wc_pkg::MIN_MATCH)) begin
				tok_q.tag          <= lz77wc_pkg::TAG_MATCH;
				tok_q.offset       <= lz77wc_pkg::OFFSET_W'(dist_c);
				tok_q.match_length <= lz77wc_pkg::MLEN_W'(best_q);
				tok_q.literal_byte <= '0;
			end else begin
				tok_q.tag          <= lz77wc_pkg::TAG_LITERAL;
				tok_q.offset       <= '0;
				tok_q.match_length <= '0;
				tok_q.literal_byte <= la_q[0];
			end
			tok_q.final_res <= last_q && (used_c == la_cnt_q);
		end
	end
endmodule
`default_nettype wire

[design/lz77_window_compressor_unit.sv]
// top level of the lz77 window compressor
//
//  channel   dir   word                        handshake
//  data      in    data_byte, last             valid/ready
//  token     out   tag, offset, match_length,  valid/ready
//                  literal_byte, final_res
//  cfg       in    cfg_index, cfg_data         cfg_we, no back-pressure
//
//  each token goes through check, search and emit, the search covering h history bytes
//  (h at most the clamped window_size) and the lookahead, then one push step per byte it consumes
//  search speed is set by the single read port of the history ring
//  input bytes pass through the two-entry queue and are taken only while the back end is idle
//  reset clears all control state; the history ring holds no reset
//  a stalled token output holds the back end in its emit step
`default_nettype none
module lz77_window_compressor_unit #(
	parameter int WINDOW    = 1024,
	parameter int LOOKAHEAD = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	lz77wc_in_if.sink                              data,
	lz77wc_out_if.source                           token,
	input  wire logic                              cfg_we,
	input  wire logic [lz77wc_pkg::CIDX_W-1:0]     cfg_index,
	input  wire logic [lz77wc_pkg::WSIZE_W-1:0]    cfg_data
);
	logic [lz77wc_pkg::WSIZE_W-1:0] window_size_q;
	logic [lz77wc_pkg::LSIZE_W-1:0] lookahead_size_q;
	logic                           q_valid;
	logic                           q_ready;
	lz77wc_pkg::inq_word_t          q_word;
	logic                           tok_valid;
	lz77wc_pkg::token_t             tok;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q    <= lz77wc_pkg::WINDOW_SIZE_RST;
			lookahead_size_q <= lz77wc_pkg::LOOKAHEAD_SIZE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lz77wc_pkg::CFG_WINDOW_SIZE:    window_size_q <= cfg_data;
				lz77wc_pkg::CFG_LOOKAHEAD_SIZE:
					lookahead_size_q <= cfg_data[lz77wc_pkg::LSIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// input queue
	lz77wc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.data    (data),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_word  (q_word)
	);

	// search and token engine
	lz77wc_back #(
		.WINDOW    (WINDOW),
		.LOOKAHEAD (LOOKAHEAD)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.window_size    (window_size_q),
		.lookahead_size (lookahead_size_q),
		.q_valid        (q_valid),
		.q_ready        (q_ready),
		.q_word         (q_word),
		.tok_valid      (tok_valid),
		.tok_ready      (token.ready),
		.tok            (tok)
	);

	// token port
	assign token.valid        = tok_valid;
	assign token.tag          = tok.tag;
	assign token.offset       = tok.offset;
	assign token.match_length = tok.match_length;
	assign token.literal_byte = tok.literal_byte;
	assign token.final_res    = tok.final_res;
endmodule
`default_nettype wire

[design/lz77wc_checker.sv]
// port checker for the lz77 window compressor and its bind
`default_nettype none
`include "lz77_window_compressor_unit_assert.svh"
module lz77wc_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              tvalid,
	input wire logic                              tready,
	input wire logic                              tag,
	input wire logic [lz77wc_pkg::OFFSET_W-1:0]   offset,
	input wire logic [lz77wc_pkg::MLEN_W-1:0]     match_length,
	input wire logic [lz77wc_pkg::BYTE_W-1:0]     literal_byte,
	input wire logic                              final_res
);
	// a stalled word stays offered
	`LZ77WC_ASSERT_NEXT(a_tok_hold, tvalid && !tready, tvalid)
	// a stalled word keeps its payload
	`LZ77WC_ASSERT_NEXT(a_tok_stable, tvalid && !tready, $stable(tag) && $stable(offset) && $stable(match_length) && $stable(literal_byte) && $stable(final_res))
	// literal tokens carry no back-reference
	`LZ77WC_ASSERT_NOW(a_lit_fields, tvalid && (tag == lz77wc_pkg::TAG_LITERAL), (offset == '0) && (match_length == '0))
	// match tokens carry no literal
	`LZ77WC_ASSERT_NOW(a_match_fields, tvalid && (tag == lz77wc_pkg::TAG_MATCH), literal_byte == '0)
endmodule

bind lz77_window_compressor_unit lz77wc_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.tvalid       (token.valid),
	.tready       (token.ready),
	.tag          (token.tag),
	.offset       (token.offset),
	.match_length (token.match_length),
	.literal_byte (token.literal_byte),
	.final_res    (token.final_res)
);
`default_nettype wire

[bench/lz77_window_compressor_unit_test.sv]
// testbench of the lz77 window compressor: directed and random streams checked against a token predictor
`timescale 1ns / 1ps
`default_nettype none
module lz77_window_compressor_unit_test;

	localparam int WIN = 1024;
	localparam int LA  = 16;
	localparam logic [lz77wc_pkg::CIDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int SETTLE = 1200;
	localparam longint CYCLE_LIMIT = 4000000;

	// token predictor and store of expected tokens
	class token_scoreboard;
		logic [7:0] hist [WIN];
		int hcount, hhead;
		logic [7:0] la [LA];
		int lcount;
		int wsize, lsize;
		lz77wc_pkg::token_t due [$];
		int errors, tokens;

		function new();
			hcount = 0; hhead = 0; lcount = 0;
			wsize = lz77wc_pkg::WINDOW_SIZE_RST; lsize = lz77wc_pkg::LOOKAHEAD_SIZE_RST;
			errors = 0; tokens = 0;
		endfunction

		function void set_reg(logic [lz77wc_pkg::CIDX_W-1:0] idx,
			logic [lz77wc_pkg::WSIZE_W-1:0] v);
			if (idx == lz77wc_pkg::CFG_WINDOW_SIZE)
				wsize = v;
			else if (idx == lz77wc_pkg::CFG_LOOKAHEAD_SIZE)
				lsize = v[lz77wc_pkg::LSIZE_W-1:0];
		endfunction

		function int eff_w();
			return wsize < 1 ? 1 : (wsize > WIN ? WIN : wsize);
		endfunction

		function int eff_l();
			return lsize < 1 ? 1 : (lsize > LA ? LA : lsize);
		endfunction

		// byte k of recent history followed by the lookahead
		function logic [7:0] seq_at(int k, int h);
			if (k < h)
				return hist[(hhead + WIN - h + k) % WIN];
			k -= h;
			return (k < lcount) ? la[k] : 8'h00;
		endfunction

		function void emit();
			int h, bound, best, back_dist, used, len;
			lz77wc_pkg::token_t t;
			h = hcount < eff_w() ? hcount : eff_w();
			bound = eff_l() < lcount ? eff_l() : lcount;
			best = 0; back_dist = 0;
			// oldest start first, strict compare keeps the oldest on a tie
			for (int i = 0; i < h; i++) begin
				len = 0;
				while (len < bound && seq_at(i + len, h) == seq_at(h + len, h))
					len++;
				if (len > best) begin
					best = len;
					back_dist = h - i;
				end
			end
			t = '0;
			if (best >= lz77wc_pkg::MIN_MATCH) begin
				t.tag = lz77wc_pkg::TAG_MATCH;
				t.offset = lz77wc_pkg::OFFSET_W'(back_dist);
				t.match_length = lz77wc_pkg::MLEN_W'(best);
				used = best;
			end else begin
				t.tag = lz77wc_pkg::TAG_LITERAL;
				t.literal_byte = la[0];
				used = 1;
			end
			due = {due, t};
			for (int j = 0; j < used; j++) begin
				hist[hhead] = la[j];
				hhead = (hhead + 1) % WIN;
				if (hcount < WIN) hcount++;
			end
			for (int j = 0; j < lcount - used; j++)
				la[j] = la[j + used];
			lcount -= used;
		endfunction

		// accepted input word
		function void note(logic [7:0] b, logic fin);
			int n;
			n = 0;
			if (lcount < LA) begin
				la[lcount] = b;
				lcount++;
			end
			if (fin) begin
				while (lcount > 0 && n < LA) begin
					emit();
					n++;
				end
				if (n > 0) due[due.size() - 1].final_res = 1'b1;
				lcount = 0; hcount = 0; hhead = 0;
			end else begin
				while (lcount > 0 && lcount >= eff_l() && n < LA) begin
					emit();
					n++;
				end
			end
		endfunction

		task report(string what, int got, int want);
			$display("mismatch on token %0d: %s got %0d expected %0d", tokens, what, got, want);
			errors++;
		endtask

		// accepted output word
		task check(lz77wc_pkg::token_t got);
			lz77wc_pkg::token_t want;
			if (due.size() == 0) begin
				report("unexpected token, tag", got.tag, -1);
			end else begin
				want = due.pop_front();
				if (got.tag !== want.tag) report("tag", got.tag, want.tag);
				if (got.offset !== want.offset) report("offset", got.offset, want.offset);
				if (got.match_length !== want.match_length)
					report("match_length", got.match_length, want.match_length);
				if (got.literal_byte !== want.literal_byte)
					report("literal_byte", got.literal_byte, want.literal_byte);
				if (got.final_res !== want.final_res)
					report("final_res", got.final_res, want.final_res);
			end
			tokens++;
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [lz77wc_pkg::CIDX_W-1:0] cfg_index;
	logic [lz77wc_pkg::WSIZE_W-1:0] cfg_data;
	lz77wc_in_if data();
	lz77wc_out_if token();

	token_scoreboard sb;
	bit quiet;
	int stall_left = 0;
	int words_sent;
	longint cycles = 0;
	logic [7:0] sent [$];

	lz77_window_compressor_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.data(data),
		.token(token),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 12 ns clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// token sink with random stall bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			token.ready <= 1'b0;
		end else begin
			if (token.valid && token.ready)
				sb.check('{token.tag, token.offset, token.match_length,
					token.literal_byte, token.final_res});
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				token.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall_left <= $urandom_range(0, 10);
				token.ready <= 1'b0;
			end else begin
				token.ready <= 1'b1;
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("lz77_window_compressor_unit_test: FAIL");
			$finish;
		end
	end

	// one input word, with an optional idle burst before it
	task send_word(logic [7:0] b, logic fin);
		int gap;
		gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
		if (gap > 0) begin
			data.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		data.valid <= 1'b1;
		data.data_byte <= b;
		data.last <= fin;
		do @(posedge clk); while (!data.ready);
		sb.note(b, fin);
		sent = {sent, b};
		words_sent++;
	endtask

	// let all expected tokens drain, then the block settle
	task drain();
		data.valid <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task write_reg(logic [lz77wc_pkg::CIDX_W-1:0] idx, logic [lz77wc_pkg::WSIZE_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, v);
	endtask

	// byte with a good chance of repeating recent content
	function logic [7:0] pick_byte(logic [7:0] base);
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 8'(base + $urandom_range(0, 2));
		else if (r < 85 && sent.size() > 0)
			return sent[sent.size() - 1 - $urandom_range(0, sent.size() > 40 ? 39 : sent.size() - 1)];
		return 8'($urandom_range(0, 255));
	endfunction

	// random streams; the last one may stay open across a setting change
	task run_streams(int count, bit close_all);
		int len;
		logic [7:0] base;
		while (count > 0) begin
			len = $urandom_range(1, 30);
			if (len > count) len = count;
			base = 8'($urandom_range(0, 255));
			for (int i = 0; i < len; i++)
				send_word(pick_byte(base),
					(i == len - 1) && (close_all || count > len || $urandom_range(0, 1)));
			count -= len;
		end
	endtask

	int wtab [8] = '{1, 37, 2000, 0, 8, 2047, 300, 1024};
	int ltab [8] = '{0, 1, 2, 3, 5, 31, 4, 16};
	logic [7:0] opening [22] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h61, 8'h62, 8'h63,
		8'h61, 8'h62, 8'h63, 8'h61, 8'h62, 8'h63, 8'h61, 8'h62, 8'h63,
		8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41};

	initial begin
		sb = new();
		quiet = 1'b0;
		words_sent = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		data.valid = 1'b0;
		data.data_byte = '0;
		data.last = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, repeats, a match running into the lookahead
		for (int i = 0; i < 22; i++)
			send_word(opening[i], i == 21);
		send_word(8'h7E, 1'b1);
		drain();

		// settings sweep, extremes and out of range values included
		for (int p = 0; p < 8; p++) begin
			if (p == 7) quiet = 1'b1;
			write_reg(lz77wc_pkg::CFG_WINDOW_SIZE, lz77wc_pkg::WSIZE_W'(wtab[p]));
			write_reg(lz77wc_pkg::CFG_LOOKAHEAD_SIZE, lz77wc_pkg::WSIZE_W'(ltab[p]));
			if (p == 2) write_reg(CFG_UNUSED, 11'h7FF);
			run_streams(p == 2 || p == 7 ? 12 : 18, p == 7);
			drain();
		end

		$display("ran %0d input words through 8 window and lookahead settings", words_sent);
		$display("checked %0d tokens, %0d mismatches", sb.tokens, sb.errors);
		if (sb.errors == 0 && sb.due.size() == 0)
			$display("lz77_window_compressor_unit_test: PASS");
		else
			$display("lz77_window_compressor_unit_test: FAIL");
		$finish;
	end
endmodule
`default_nettype wire
